/* design/kl_pkg.sv */
`timescale 1ns / 1ps

package kl_pkg;

  // field widths
  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int LINE_BITS   = 32;
  localparam int KIND_BITS   = 6;
  localparam int ERR_BITS    = 2;
  localparam int CHAR_BITS   = 8;

  // packed stream widths: offset, length, line, error code, padded to bytes
  localparam int OUT_FIELD_W = OFFSET_BITS + LENGTH_BITS + LINE_BITS + ERR_BITS;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // keyword set
  localparam int NKW        = 15;
  localparam int KW_MAXLEN  = 8;

  // token kinds
  localparam logic [KIND_BITS-1:0] TK_END    = 6'd0;
  localparam logic [KIND_BITS-1:0] TK_ERR    = 6'd1;
  localparam logic [KIND_BITS-1:0] TK_SEMI   = 6'd2;
  localparam logic [KIND_BITS-1:0] TK_COMMA  = 6'd3;
  localparam logic [KIND_BITS-1:0] TK_PLUS   = 6'd4;
  localparam logic [KIND_BITS-1:0] TK_MINUS  = 6'd5;
  localparam logic [KIND_BITS-1:0] TK_STAR   = 6'd6;
  localparam logic [KIND_BITS-1:0] TK_DSLASH = 6'd7;
  localparam logic [KIND_BITS-1:0] TK_LT     = 6'd8;
  localparam logic [KIND_BITS-1:0] TK_LE     = 6'd9;
  localparam logic [KIND_BITS-1:0] TK_GT     = 6'd10;
  localparam logic [KIND_BITS-1:0] TK_GE     = 6'd11;
  localparam logic [KIND_BITS-1:0] TK_ASSIGN = 6'd12;
  localparam logic [KIND_BITS-1:0] TK_EQ     = 6'd13;
  localparam logic [KIND_BITS-1:0] TK_NE     = 6'd14;
  localparam logic [KIND_BITS-1:0] TK_LPAREN = 6'd15;
  localparam logic [KIND_BITS-1:0] TK_RPAREN = 6'd16;
  localparam logic [KIND_BITS-1:0] TK_LBRACE = 6'd17;
  localparam logic [KIND_BITS-1:0] TK_RBRACE = 6'd18;
  localparam logic [KIND_BITS-1:0] TK_INT    = 6'd19;
  localparam logic [KIND_BITS-1:0] TK_IDENT  = 6'd20;
  localparam logic [KIND_BITS-1:0] TK_KW0    = 6'd21;

  // error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_CHAR = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_OP   = 2'd2;

  // keyword spellings, right-justified, first character in the highest used byte
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [NKW] = '{
    64'("and"), 64'("break"), 64'("continue"), 64'("else"), 64'("false"),
    64'("if"), 64'("loop"), 64'("mut"), 64'("nil"), 64'("not"),
    64'("or"), 64'("true"), 64'("until"), 64'("while"), 64'("with")
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd3, 4'd5, 4'd8, 4'd4, 4'd5, 4'd2, 4'd4, 4'd3,
    4'd3, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd4
  };

  // one result beat
  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [ERR_BITS-1:0]    err;
    logic                   last;
  } tok_t;

  // keep candidates whose character at position idx equals c
  function automatic logic [NKW-1:0] kw_narrow(input logic [NKW-1:0] cand,
                                               input logic [LENGTH_BITS-1:0] idx,
                                               input logic [CHAR_BITS-1:0] c);
    logic [NKW-1:0] res;
    logic [2:0]     pos;
    res = '0;
    pos = '0;
    for (int k = 0; k < NKW; k++) begin
      if (cand[k] && (idx < LENGTH_BITS'(KW_LEN[k]))) begin
        pos = 3'(KW_LEN[k] - 4'd1 - idx[3:0]);
        if (KW_TEXT[k][{pos, 3'b000} +: 8] == c) res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  // first remaining candidate whose length matches, else identifier
  function automatic logic [KIND_BITS-1:0] kw_kind(input logic [NKW-1:0] cand,
                                                   input logic [LENGTH_BITS-1:0] len);
    logic [KIND_BITS-1:0] kind;
    logic                 hit;
    kind = TK_IDENT;
    hit  = 1'b0;
    for (int k = 0; k < NKW; k++) begin
      if (!hit && cand[k] && (LENGTH_BITS'(KW_LEN[k]) == len)) begin
        kind = TK_KW0 + KIND_BITS'(k);
        hit  = 1'b1;
      end
    end
    return kind;
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

endpackage

/* design/keyword_lexer_top.sv */
`timescale 1ns / 1ps

// channel  role    handshake              payload
// in_      slave   in_tvalid/in_tready    tdata char_code
// out_     master  out_tvalid/out_tready  tuser kind; tdata start/length/line/error; tlast
// cfg_     slave   cfg_valid/cfg_ready    cfg_data start_line
//
// one source byte per cycle while in_tready is high; its zero, one or two tokens are decoded in that cycle
// and written to a four-beat result queue, so a beat is offered the cycle after the byte
// in_tready is low while fewer than two queue slots are free, so with out_tready high
// the rate is one byte per cycle, lower only while every byte yields two tokens
// out_tready low stalls the queue, and the input too once fewer than two queue slots are free
// rst_n is synchronous: scanner idle, position 0, start_line 1, queue empty
module keyword_lexer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] char_code
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [kl_pkg::OUT_DATA_W-1:0] out_tdata, // [31:0] start_offset, [47:32]
                                                   // token_length, [79:48] line_number,
                                                   // [81:80] error_code, rest zero
  output logic [5:0]                   out_tuser,  // [5:0] token_kind
  output logic                         out_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [31:0]                  cfg_data    // [31:0] start_line
);
  import kl_pkg::*;

  // scanner modes
  localparam logic [2:0] MD_IDLE  = 3'd0;
  localparam logic [2:0] MD_INT   = 3'd1;
  localparam logic [2:0] MD_IDENT = 3'd2;
  localparam logic [2:0] MD_LT    = 3'd3;
  localparam logic [2:0] MD_GT    = 3'd4;
  localparam logic [2:0] MD_EQ    = 3'd5;
  localparam logic [2:0] MD_BANG  = 3'd6;
  localparam logic [2:0] MD_SLASH = 3'd7;

  localparam int QDEPTH = 4;

  logic [2:0]             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [LENGTH_BITS-1:0] run_len_r, run_len_nxt;
  logic [NKW-1:0]         cand_r, cand_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]   start_line_r;

  tok_t                   q_r [QDEPTH];
  logic [1:0]             wr_ptr_r, rd_ptr_r;
  logic [2:0]             count_r, count_nxt;

  logic                   in_fire, out_fire, cfg_fire;
  logic [7:0]             c;
  logic                   pend_v, cur_v, done;
  tok_t                   pend, cur, beat0, beat1;
  logic [1:0]             push_n;

  assign c         = in_tdata;
  assign in_tready = (count_r <= 3'd2);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (count_r != 3'd0);
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // token decode for one byte
  always_comb begin
    mode_nxt    = mode_r;
    tstart_nxt  = tstart_r;
    run_len_nxt = run_len_r;
    cand_nxt    = cand_r;
    line_nxt    = line_r;
    pos_nxt     = pos_r + 1'b1;
    pend_v      = 1'b0;
    cur_v       = 1'b0;
    done        = 1'b0;
    pend        = '0;
    cur         = '0;
    pend.line   = line_r;
    pend.start  = tstart_r;
    cur.line    = line_r;
    cur.start   = pos_r;
    cur.len     = LENGTH_BITS'(1);

    // close or extend the pending token
    if (mode_r == MD_INT || mode_r == MD_IDENT) begin
      if ((mode_r == MD_INT) ? is_digit(c) : (is_letter(c) || is_digit(c))) begin
        if (mode_r == MD_IDENT) cand_nxt = kw_narrow(cand_r, run_len_r, c);
        if (run_len_r != '1) run_len_nxt = run_len_r + 1'b1;
        done = 1'b1;
      end else begin
        pend_v    = 1'b1;
        pend.kind = (mode_r == MD_INT) ? TK_INT : kw_kind(cand_r, run_len_r);
        pend.len  = run_len_r;
      end
    end else if (mode_r != MD_IDLE) begin
      pend_v = 1'b1;
      if (c == ((mode_r == MD_SLASH) ? 8'h2f : 8'h3d)) begin
        // two-character operator
        done     = 1'b1;
        mode_nxt = MD_IDLE;
        pend.len = LENGTH_BITS'(2);
        case (mode_r)
          MD_SLASH: pend.kind = TK_DSLASH;
          MD_LT:    pend.kind = TK_LE;
          MD_GT:    pend.kind = TK_GE;
          MD_EQ:    pend.kind = TK_EQ;
          default:  pend.kind = TK_NE;
        endcase
      end else begin
        pend.len = LENGTH_BITS'(1);
        case (mode_r)
          MD_LT:   pend.kind = TK_LT;
          MD_GT:   pend.kind = TK_GT;
          MD_EQ:   pend.kind = TK_ASSIGN;
          default: begin
            // lone slash or lone bang
            pend.kind = TK_ERR;
            pend.err  = ERR_OP;
          end
        endcase
      end
    end

    // scan the byte itself
    if (!done) begin
      mode_nxt    = MD_IDLE;
      run_len_nxt = '0;
      cand_nxt    = '1;
      case (c)
        8'h00: begin
          cur_v    = 1'b1;
          cur.kind = TK_END;
          cur.len  = '0;
          pos_nxt  = '0;
          line_nxt = start_line_r;
        end
        8'h0a:               line_nxt = line_r + 1'b1;
        8'h20, 8'h09, 8'h0d: ;
        8'h3b: begin cur_v = 1'b1; cur.kind = TK_SEMI;   end
        8'h2c: begin cur_v = 1'b1; cur.kind = TK_COMMA;  end
        8'h2b: begin cur_v = 1'b1; cur.kind = TK_PLUS;   end
        8'h2d: begin cur_v = 1'b1; cur.kind = TK_MINUS;  end
        8'h2a: begin cur_v = 1'b1; cur.kind = TK_STAR;   end
        8'h28: begin cur_v = 1'b1; cur.kind = TK_LPAREN; end
        8'h29: begin cur_v = 1'b1; cur.kind = TK_RPAREN; end
        8'h7b: begin cur_v = 1'b1; cur.kind = TK_LBRACE; end
        8'h7d: begin cur_v = 1'b1; cur.kind = TK_RBRACE; end
        8'h3c: mode_nxt = MD_LT;
        8'h3e: mode_nxt = MD_GT;
        8'h3d: mode_nxt = MD_EQ;
        8'h21: mode_nxt = MD_BANG;
        8'h2f: mode_nxt = MD_SLASH;
        default: begin
          if (is_digit(c)) begin
            mode_nxt = MD_INT;
          end else if (is_letter(c)) begin
            mode_nxt = MD_IDENT;
            cand_nxt = kw_narrow('1, '0, c);
          end else begin
            cur_v    = 1'b1;
            cur.kind = TK_ERR;
            cur.err  = ERR_CHAR;
          end
        end
      endcase
      // every multi-byte token opens here
      if (mode_nxt != MD_IDLE) begin
        tstart_nxt  = pos_r;
        run_len_nxt = LENGTH_BITS'(1);
      end
    end
  end

  // order the beats, last flag on the final one
  always_comb begin
    beat0  = pend_v ? pend : cur;
    beat1  = cur;
    push_n = 2'({1'b0, pend_v} + {1'b0, cur_v});
    beat0.last = (push_n == 2'd1);
    beat1.last = 1'b1;
    if (!in_fire) push_n = '0;
  end

  assign count_nxt = count_r + {1'b0, push_n} - {2'b00, out_fire};

  // scanner state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MD_IDLE;
      tstart_r     <= '0;
      run_len_r    <= '0;
      cand_r       <= '1;
      line_r       <= LINE_BITS'(1);
      pos_r        <= '0;
      start_line_r <= LINE_BITS'(1);
    end else begin
      if (in_fire) begin
        mode_r    <= mode_nxt;
        tstart_r  <= tstart_nxt;
        run_len_r <= run_len_nxt;
        cand_r    <= cand_nxt;
        pos_r     <= pos_nxt;
      end
      // a new start line applies at once only at the start of a source
      if (cfg_fire && mode_r == MD_IDLE && pos_r == '0) begin
        line_r <= cfg_data;
      end else if (in_fire) begin
        line_r <= line_nxt;
      end
      if (cfg_fire) start_line_r <= cfg_data;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      rd_ptr_r <= rd_ptr_r + {1'b0, out_fire};
      count_r  <= count_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= beat0;
    if (push_n == 2'd2) q_r[wr_ptr_r + 2'd1] <= beat1;
  end

  // output beat
  assign out_tuser = q_r[rd_ptr_r].kind;
  assign out_tlast = q_r[rd_ptr_r].last;
  assign out_tdata = OUT_DATA_W'({q_r[rd_ptr_r].err, q_r[rd_ptr_r].line,
                                  q_r[rd_ptr_r].len, q_r[rd_ptr_r].start});

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(QDEPTH))
    else $error("result queue overflow");

  // end of source always leaves a beat to send
  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tdata == 8'h00) |=> out_tvalid)
    else $error("end token missing");

  // end of source rewinds the position and idles the scanner
  a_end_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tdata == 8'h00) |=> (pos_r == '0 && mode_r == MD_IDLE))
    else $error("source not rewound");

  // an open token always has a nonzero length
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MD_IDLE) |-> (run_len_r != '0))
    else $error("open token with zero length");

endmodule

/* test/keyword_lexer_top_test.sv */
`timescale 1ns / 1ps

module keyword_lexer_top_test;

  import kl_pkg::*;

  localparam int LEN_LSB     = OFFSET_BITS;
  localparam int LINE_LSB    = LEN_LSB + LENGTH_BITS;
  localparam int ERR_LSB     = LINE_LSB + LINE_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int NUM_OPS     = 19;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_INT, MODE_IDENT, MODE_LT, MODE_GT, MODE_EQ, MODE_BANG, MODE_SLASH
  } scan_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [5:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [31:0]           cfg_data = '0;

  // source bytes waiting to be sent and tokens still to come back
  logic [7:0] src_bytes_q [$];
  tok_t       expected_tokens [$];

  int send_idle_pct = 9;
  int recv_idle_pct = 58;
  int mismatch_count = 0;
  int stall_cycles = 0;

  // scanner shadow state
  logic [31:0]      first_line = 32'd1;
  scan_mode_e       mode = MODE_IDLE;
  logic [31:0]      tok_start = '0;
  logic [15:0]      run_len = '0;
  logic [NKW-1:0]   cand = '1;
  logic [31:0]      line_cnt = 32'd1;
  logic [31:0]      pos = '0;

  keyword_lexer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // keywords at 0..14 in kind order, operators after them
  function automatic string spelling(int k);
    case (k)
      0:  return "and";
      1:  return "break";
      2:  return "continue";
      3:  return "else";
      4:  return "false";
      5:  return "if";
      6:  return "loop";
      7:  return "mut";
      8:  return "nil";
      9:  return "not";
      10: return "or";
      11: return "true";
      12: return "until";
      13: return "while";
      14: return "with";
      15: return ";";
      16: return ",";
      17: return "+";
      18: return "-";
      19: return "*";
      20: return "//";
      21: return "<";
      22: return "<=";
      23: return ">";
      24: return ">=";
      25: return "=";
      26: return "==";
      27: return "!=";
      28: return "(";
      29: return ")";
      30: return "{";
      31: return "}";
      32: return "/";
      default: return "!";
    endcase
  endfunction

  function automatic logic num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // drop keywords whose character at idx differs from c
  function automatic logic [NKW-1:0] narrow_cand(input logic [NKW-1:0] cand_in,
                                                 input logic [15:0] idx,
                                                 input logic [7:0] c);
    logic [NKW-1:0] res;
    string          w;
    res = '0;
    if (idx < KW_MAXLEN) begin
      for (int k = 0; k < NKW; k++) begin
        w = spelling(k);
        if (cand_in[k] && int'(idx) < w.len() && w[int'(idx)] == c) res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  // first surviving keyword of the run's length, else a plain identifier
  function automatic logic [KIND_BITS-1:0] word_kind();
    logic [KIND_BITS-1:0] kind;
    logic                 found;
    string                w;
    kind  = TK_IDENT;
    found = 1'b0;
    for (int k = 0; k < NKW; k++) begin
      w = spelling(k);
      if (!found && cand[k] && run_len == 16'(w.len())) begin
        kind  = TK_KW0 + KIND_BITS'(k);
        found = 1'b1;
      end
    end
    return kind;
  endfunction

  function automatic tok_t make_tok(input logic [KIND_BITS-1:0] kind,
                                    input logic [31:0] start,
                                    input logic [15:0] len,
                                    input logic [ERR_BITS-1:0] err);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line_cnt;
    t.err   = err;
    t.last  = 1'b0;
    return t;
  endfunction

  // advance the shadow scanner by one byte and queue the tokens it completes
  function automatic void predict_tokens(input logic [7:0] c);
    tok_t toks [2];
    int   n;
    logic paired;
    logic eos;
    n      = 0;
    paired = 1'b0;
    eos    = 1'b0;
    if ((mode == MODE_INT && num_char(c)) ||
        (mode == MODE_IDENT && (alpha_char(c) || num_char(c)))) begin
      // run keeps growing
      if (mode == MODE_IDENT) cand = narrow_cand(cand, run_len, c);
      if (run_len != '1) run_len = run_len + 16'd1;
    end else begin
      // close a pending token
      if (mode == MODE_INT || mode == MODE_IDENT) begin
        toks[n] = make_tok(mode == MODE_INT ? TK_INT : word_kind(), tok_start, run_len,
                           ERR_NONE);
        n++;
      end else if (mode != MODE_IDLE) begin
        if (c == ((mode == MODE_SLASH) ? "/" : "=")) begin
          case (mode)
            MODE_SLASH: toks[n] = make_tok(TK_DSLASH, tok_start, 16'd2, ERR_NONE);
            MODE_LT:    toks[n] = make_tok(TK_LE, tok_start, 16'd2, ERR_NONE);
            MODE_GT:    toks[n] = make_tok(TK_GE, tok_start, 16'd2, ERR_NONE);
            MODE_EQ:    toks[n] = make_tok(TK_EQ, tok_start, 16'd2, ERR_NONE);
            default:    toks[n] = make_tok(TK_NE, tok_start, 16'd2, ERR_NONE);
          endcase
          n++;
          paired = 1'b1;
          mode   = MODE_IDLE;
        end else begin
          case (mode)
            MODE_LT: toks[n] = make_tok(TK_LT, tok_start, 16'd1, ERR_NONE);
            MODE_GT: toks[n] = make_tok(TK_GT, tok_start, 16'd1, ERR_NONE);
            MODE_EQ: toks[n] = make_tok(TK_ASSIGN, tok_start, 16'd1, ERR_NONE);
            default: toks[n] = make_tok(TK_ERR, tok_start, 16'd1, ERR_OP);
          endcase
          n++;
        end
      end
      // then scan the byte itself
      if (!paired) begin
        mode    = MODE_IDLE;
        run_len = '0;
        cand    = '1;
        case (c)
          8'h00: begin
            toks[n] = make_tok(TK_END, pos, 16'd0, ERR_NONE);
            n++;
            eos      = 1'b1;
            line_cnt = first_line;
          end
          "\n":             line_cnt = line_cnt + 32'd1;
          " ", "\t", "\r":  ;
          ";": begin toks[n] = make_tok(TK_SEMI, pos, 16'd1, ERR_NONE);   n++; end
          ",": begin toks[n] = make_tok(TK_COMMA, pos, 16'd1, ERR_NONE);  n++; end
          "+": begin toks[n] = make_tok(TK_PLUS, pos, 16'd1, ERR_NONE);   n++; end
          "-": begin toks[n] = make_tok(TK_MINUS, pos, 16'd1, ERR_NONE);  n++; end
          "*": begin toks[n] = make_tok(TK_STAR, pos, 16'd1, ERR_NONE);   n++; end
          "(": begin toks[n] = make_tok(TK_LPAREN, pos, 16'd1, ERR_NONE); n++; end
          ")": begin toks[n] = make_tok(TK_RPAREN, pos, 16'd1, ERR_NONE); n++; end
          "{": begin toks[n] = make_tok(TK_LBRACE, pos, 16'd1, ERR_NONE); n++; end
          "}": begin toks[n] = make_tok(TK_RBRACE, pos, 16'd1, ERR_NONE); n++; end
          "<": mode = MODE_LT;
          ">": mode = MODE_GT;
          "=": mode = MODE_EQ;
          "!": mode = MODE_BANG;
          "/": mode = MODE_SLASH;
          default: begin
            if (num_char(c)) begin
              mode = MODE_INT;
            end else if (alpha_char(c)) begin
              cand = narrow_cand('1, 16'd0, c);
              mode = MODE_IDENT;
            end else begin
              toks[n] = make_tok(TK_ERR, pos, 16'd1, ERR_CHAR);
              n++;
            end
          end
        endcase
        if (mode != MODE_IDLE) begin
          tok_start = pos;
          run_len   = 16'd1;
        end
      end
    end
    pos = eos ? 32'd0 : pos + 32'd1;
    for (int i = 0; i < n; i++) begin
      toks[i].last = (i == n - 1);
      expected_tokens.push_back(toks[i]);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // input driver and random output ready
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (src_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= src_bytes_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on accepted input and config beats, check result beats
  always @(posedge clk) begin : monitor
    tok_t  got;
    tok_t  want;
    string diff;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        first_line = cfg_data;
        if (mode == MODE_IDLE && pos == 0) line_cnt = cfg_data;
      end
      if (in_tvalid && in_tready) predict_tokens(in_tdata);
      if (out_tvalid && out_tready) begin
        got.kind  = out_tuser;
        got.start = out_tdata[0 +: OFFSET_BITS];
        got.len   = out_tdata[LEN_LSB +: LENGTH_BITS];
        got.line  = out_tdata[LINE_LSB +: LINE_BITS];
        got.err   = out_tdata[ERR_LSB +: ERR_BITS];
        got.last  = out_tlast;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d start %0d", got.kind,
                                    got.start));
        end else begin
          want = expected_tokens.pop_front();
          diff = "";
          if (got.kind !== want.kind)   diff = {diff, " kind"};
          if (got.start !== want.start) diff = {diff, " start"};
          if (got.len !== want.len)     diff = {diff, " length"};
          if (got.line !== want.line)   diff = {diff, " line"};
          if (got.err !== want.err)     diff = {diff, " error"};
          if (got.last !== want.last)   diff = {diff, " last"};
          if (diff != "")
            report_mismatch($sformatf(
              "%s wrong: got %0d/%0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d/%0d",
              diff, got.kind, got.start, got.len, got.line, got.err, got.last,
              want.kind, want.start, want.len, want.line, want.err, want.last));
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) src_bytes_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_word_char(input bit letters_only);
    int r;
    r = $urandom_range(letters_only ? 51 : 61);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return 8'("0" + r - 52);
  endfunction

  function automatic logic [7:0] rand_space();
    string ws;
    ws = " \t\r\n";
    return ws[$urandom_range(3)];
  endfunction

  // random sources of mostly well-formed tokens, some noise
  function automatic void gen_segment(input int budget);
    int    done;
    int    src_len;
    int    r;
    string w;
    done = 0;
    while (done < budget) begin
      src_len = $urandom_range(60, 4);
      for (int b = 0; b < src_len; ) begin
        r = src_bytes_q.size();
        case ($urandom_range(9))
          0, 1: push_str(spelling($urandom_range(NKW - 1)));
          2: begin
            // near misses of keywords
            w = spelling($urandom_range(NKW - 1));
            if ($urandom_range(1)) begin
              push_str(w.substr(0, $urandom_range(w.len() - 2)));
            end else begin
              push_str(w);
              src_bytes_q.push_back(rand_word_char(1'b0));
            end
          end
          3, 4: begin
            src_bytes_q.push_back(rand_word_char(1'b1));
            repeat ($urandom_range(6)) src_bytes_q.push_back(rand_word_char(1'b0));
          end
          5: begin
            repeat ($urandom_range(6, 1)) src_bytes_q.push_back(8'("0" + $urandom_range(9)));
            if ($urandom_range(3) == 0) src_bytes_q.push_back(rand_word_char(1'b1));
          end
          6, 7: push_str(spelling(NKW + $urandom_range(NUM_OPS - 1)));
          8:    src_bytes_q.push_back(rand_space());
          default: src_bytes_q.push_back(8'($urandom_range(255)));
        endcase
        if ($urandom_range(99) < 60) src_bytes_q.push_back(rand_space());
        b    += src_bytes_q.size() - r;
        done += src_bytes_q.size() - r;
      end
      // the last source is sometimes left open across a config write
      if (done < budget || $urandom_range(1)) begin
        src_bytes_q.push_back(8'h00);
        done++;
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (src_bytes_q.size() != 0 || in_tvalid || expected_tokens.size() != 0);
  endtask

  task automatic write_start_line(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] line_seeds [9];
    line_seeds[0] = 32'h0000_0000;
    line_seeds[1] = 32'hFFFF_FFFF;
    line_seeds[2] = $urandom();
    line_seeds[3] = 32'hFFFF_FFFE;
    line_seeds[4] = 32'h0000_0001;
    line_seeds[5] = $urandom();
    line_seeds[6] = 32'h7FFF_FFFF;
    line_seeds[7] = $urandom();
    line_seeds[8] = 32'h0000_0000;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: operators, lone slash and bang, digits into letters, odd bytes
    push_str("<x<=>x>==x==!x!=/x//;,+-*(){}9z@ \t\r\nwhile1 ab");
    src_bytes_q.push_back(8'h80);
    src_bytes_q.push_back(8'hFF);
    src_bytes_q.push_back(8'h7F);
    push_str("ab");
    src_bytes_q.push_back(8'h00);
    push_str("!");
    src_bytes_q.push_back(8'h00);
    push_str("/");
    src_bytes_q.push_back(8'h00);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 9 : (p == 1) ? 58 : 0;
      recv_idle_pct = (p == 0) ? 58 : (p == 1) ? 9 : 0;
      for (int s = 0; s < 3; s++) begin
        gen_segment(200);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        write_start_line(line_seeds[p * 3 + s]);
      end
    end

    wait_drained();
    repeat (4 * SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
